@@ design/slid_pkg.sv @@
// Shared types, constants and control structs for the sorted list unit.
`default_nettype none
package slid_pkg;

  localparam int CAPACITY = 16;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [4:0]              entry_count;
    logic [4:0]              removed_count;
    logic signed [DATA_W-1:0] read_value;
  } out_t;

  typedef struct packed {
    logic load;
    logic ins_first;
    logic ins_step;
    logic put_val;
    logic del_first;
    logic del_step;
    logic del_end;
    logic rd_issue;
    logic rd_take;
    logic set_full;
    logic set_none;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       p_zero;
    logic       p_one;
    logic       ins_stop;
    logic       del_last;
    logic       rd_ok;
  } sts_t;

endpackage
`default_nettype wire

@@ design/slid_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module slid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/slid_dp.sv @@
// Datapath: list storage, walk pointers, counters and result register.
`default_nettype none
module slid_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire slid_pkg::in_t  in_data,
  input  wire slid_pkg::cmd_t cmd,
  output slid_pkg::sts_t      sts,
  output slid_pkg::out_t      out_data
);

  logic [1:0]                        op_r;
  logic signed [slid_pkg::DATA_W-1:0] val_r;
  logic [slid_pkg::POS_W-1:0]        pos_r;
  logic [slid_pkg::CNT_W-1:0]        held_r;
  logic [slid_pkg::CNT_W-1:0]        p_r;
  logic [slid_pkg::CNT_W-1:0]        k_r;
  logic [slid_pkg::CNT_W-1:0]        keep_r;
  logic [slid_pkg::CNT_W-1:0]        rem_r;
  logic [1:0]                        st_r;
  logic signed [slid_pkg::DATA_W-1:0] rv_r;
  slid_pkg::out_t                    out_r;

  logic [slid_pkg::CNT_W-1:0]  p_m1, p_m2, k_p1;
  logic                        del_hit;
  logic                        we, re;
  logic [slid_pkg::AW-1:0]     waddr, raddr;
  logic [slid_pkg::DATA_W-1:0] wdata, rdata;

  assign p_m1    = p_r - slid_pkg::CNT_W'(1);
  assign p_m2    = p_r - slid_pkg::CNT_W'(2);
  assign k_p1    = k_r + slid_pkg::CNT_W'(1);
  assign del_hit = (rdata == $unsigned(val_r));

  always_comb begin
    sts.op       = op_r;
    sts.full     = (held_r == slid_pkg::CNT_W'(slid_pkg::CAPACITY));
    sts.p_zero   = (p_r == '0);
    sts.p_one    = (p_r == slid_pkg::CNT_W'(1));
    sts.ins_stop = ($signed(rdata) < val_r);
    sts.del_last = (k_p1 == held_r);
    sts.rd_ok    = (slid_pkg::CMP_W'(pos_r) < slid_pkg::CMP_W'(held_r));
  end

  always_comb begin
    we    = 1'b0;
    waddr = p_r[slid_pkg::AW-1:0];
    wdata = $unsigned(val_r);
    re    = 1'b0;
    raddr = '0;
    if (cmd.put_val) begin
      we = 1'b1;
    end
    if (cmd.ins_first) begin
      re    = 1'b1;
      raddr = p_m1[slid_pkg::AW-1:0];
    end
    if (cmd.ins_step) begin
      we    = 1'b1;
      wdata = rdata;
      re    = ~sts.p_one;
      raddr = p_m2[slid_pkg::AW-1:0];
    end
    if (cmd.del_first) begin
      re    = 1'b1;
      raddr = '0;
    end
    if (cmd.del_step) begin
      we    = ~del_hit;
      waddr = keep_r[slid_pkg::AW-1:0];
      wdata = rdata;
      re    = ~sts.del_last;
      raddr = k_p1[slid_pkg::AW-1:0];
    end
    if (cmd.rd_issue) begin
      re    = 1'b1;
      raddr = slid_pkg::AW'(pos_r);
    end
  end

  slid_ram #(
    .WIDTH(slid_pkg::DATA_W),
    .DEPTH(slid_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.put_val) begin
      held_r <= held_r + slid_pkg::CNT_W'(1);
    end else if (cmd.del_end) begin
      held_r <= keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.opcode;
      val_r  <= in_data.value;
      pos_r  <= in_data.position;
      p_r    <= held_r;
      k_r    <= '0;
      keep_r <= '0;
      rem_r  <= '0;
      st_r   <= slid_pkg::ST_DONE;
      rv_r   <= '0;
    end
    if (cmd.ins_step) begin
      p_r <= p_m1;
    end
    if (cmd.del_step) begin
      k_r <= k_p1;
      if (del_hit) begin
        rem_r <= rem_r + slid_pkg::CNT_W'(1);
      end else begin
        keep_r <= keep_r + slid_pkg::CNT_W'(1);
      end
    end
    if (cmd.del_end && rem_r == '0) begin
      st_r <= slid_pkg::ST_NONE;
    end
    if (cmd.rd_take) begin
      rv_r <= $signed(rdata);
    end
    if (cmd.set_full) begin
      st_r <= slid_pkg::ST_FULL;
    end
    if (cmd.set_none) begin
      st_r <= slid_pkg::ST_NONE;
    end
    if (cmd.out_load) begin
      out_r.status        <= st_r;
      out_r.entry_count   <= 5'(held_r);
      out_r.removed_count <= 5'(rem_r);
      out_r.read_value    <= rv_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

@@ design/slid_ctrl.sv @@
// Controller: sequences insert, delete and read walks over the list store.
`default_nettype none
module slid_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire slid_pkg::sts_t sts,
  output slid_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_INS_CMP,
    S_INS_HEAD,
    S_DEL_RUN,
    S_DEL_END,
    S_RD_TAKE,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          slid_pkg::OP_INSERT: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_FIN;
            end else if (sts.p_zero) begin
              cmd.put_val = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.ins_first = 1'b1;
              state_nxt     = S_INS_CMP;
            end
          end
          slid_pkg::OP_DELETE: begin
            if (sts.p_zero) begin
              cmd.set_none = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              cmd.del_first = 1'b1;
              state_nxt     = S_DEL_RUN;
            end
          end
          slid_pkg::OP_READ: begin
            if (sts.rd_ok) begin
              cmd.rd_issue = 1'b1;
              state_nxt    = S_RD_TAKE;
            end else begin
              cmd.set_none = 1'b1;
              state_nxt    = S_FIN;
            end
          end
          default: begin
            cmd.set_none = 1'b1;
            state_nxt    = S_FIN;
          end
        endcase
      end
      S_INS_CMP: begin
        if (sts.ins_stop) begin
          cmd.put_val = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.ins_step = 1'b1;
          if (sts.p_one) begin
            state_nxt = S_INS_HEAD;
          end
        end
      end
      S_INS_HEAD: begin
        cmd.put_val = 1'b1;
        state_nxt   = S_FIN;
      end
      S_DEL_RUN: begin
        cmd.del_step = 1'b1;
        if (sts.del_last) begin
          state_nxt = S_DEL_END;
        end
      end
      S_DEL_END: begin
        cmd.del_end = 1'b1;
        state_nxt   = S_FIN;
      end
      S_RD_TAKE: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/sorted_list_insert_delete_unit.sv @@
// Top level of the bounded sorted list unit.
// Holds up to CAPACITY signed 32-bit entries in ascending order in a RAM with one
// write and one registered read port. One transaction in gives one result out. An
// insert walks from the tail, shifting entries up one per cycle until its place is
// found; a delete compacts the list in one pass. The single RAM read port sets the
// one-entry-per-cycle walk. A new transaction is taken while the previous result
// still waits in the output register.
`default_nettype none
module sorted_list_insert_delete_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire slid_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output slid_pkg::out_t      out_data
);

  slid_pkg::cmd_t cmd;
  slid_pkg::sts_t sts;

  slid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slid_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

@@ design/slid_checker.sv @@
// Port-level checker for the sorted list unit, bound to the top level.
`default_nettype none
module slid_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire slid_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_removed_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.removed_count != 5'd0 |-> out_data.status == slid_pkg::ST_DONE)
    else $error("entries removed without done status");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_value != '0 |-> out_data.status == slid_pkg::ST_DONE
      && out_data.removed_count == 5'd0)
    else $error("read value reported on a failed or non-read transaction");

endmodule

bind sorted_list_insert_delete_unit slid_checker u_slid_checker (.*);
`default_nettype wire

@@ tb/sorted_list_insert_delete_unit_checker.sv @@
// Checker for the sorted list unit: predicts each result and compares it on the output channel.
`timescale 1ns / 100ps
module sorted_list_insert_delete_unit_checker
  import slid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int MAX_LINES = 40;

  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_len;
  out_t                     result_q [$];
  int                       result_idx;

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
    result_idx = 0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < MAX_LINES) begin
      $display("[%0t] result %0d: %0s got %h want %h", $realtime, result_idx, what, got, want);
    end
    fail_count++;
  endtask

  function automatic out_t list_update(in_t tr);
    out_t r;
    int   at;
    int   kept;
    int   gone;
    int   i;
    r = '0;
    r.status = ST_DONE;
    case (tr.opcode)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          at = list_len;
          for (i = 0; i < list_len; i++) begin
            if (list_vals[i] >= tr.value) begin
              at = i;
              break;
            end
          end
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = tr.value;
          list_len++;
        end
      end
      OP_DELETE: begin
        kept = 0;
        gone = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == tr.value) begin
            gone++;
          end else begin
            list_vals[kept] = list_vals[i];
            kept++;
          end
        end
        list_len        = kept;
        r.removed_count = gone[4:0];
        if (gone == 0) r.status = ST_NONE;
      end
      OP_READ: begin
        if (int'(tr.position) < list_len) r.read_value = list_vals[tr.position];
        else r.status = ST_NONE;
      end
      default: r.status = ST_NONE;
    endcase
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transaction, status", 32'(out_data.status), '0);
        end else begin
          want = result_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
          if (out_data.removed_count !== want.removed_count)
            report_mismatch("removed_count", 32'(out_data.removed_count),
                            32'(want.removed_count));
          if (out_data.read_value !== want.read_value)
            report_mismatch("read_value", out_data.read_value, want.read_value);
        end
        result_idx++;
      end
      if (in_valid && in_ready) result_q.push_back(list_update(in_data));
    end
    pending <= result_q.size();
  end

endmodule

@@ tb/sorted_list_insert_delete_unit_tb.sv @@
// Testbench top for the sorted list unit: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module sorted_list_insert_delete_unit_tb;
  import slid_pkg::*;

  localparam int         LIMIT     = 400000;
  localparam int         HOLD_LEN  = 300;
  localparam int         POOL_N    = 6;
  localparam int         RECENT_N  = 48;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_token    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycles        = 0;

  logic signed [DATA_W-1:0] recent_vals [$];
  logic signed [DATA_W-1:0] value_pool [POOL_N];

  sorted_list_insert_delete_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sorted_list_insert_delete_unit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  function automatic in_t mk(logic [1:0] op, logic signed [DATA_W-1:0] v, logic [POS_W-1:0] p);
    in_t tr;
    tr.opcode   = op;
    tr.value    = v;
    tr.position = p;
    return tr;
  endfunction

  function automatic logic signed [DATA_W-1:0] insert_value();
    int k;
    k = $urandom_range(99);
    if (k < 45) return value_pool[$urandom_range(POOL_N-1)];
    if (k < 55) begin
      case ($urandom_range(3))
        0:       return 32'h7FFFFFFF;
        1:       return 32'h80000000;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic in_t random_item();
    in_t tr;
    int  pick;
    int  k;
    pick = $urandom_range(99);
    tr   = mk(OP_READ, $urandom, POS_W'($urandom_range(15)));
    if (pick < 40) begin
      tr.opcode = OP_INSERT;
      tr.value  = insert_value();
    end else if (pick < 62) begin
      tr.opcode = OP_DELETE;
      k = $urandom_range(99);
      if (k < 70 && recent_vals.size() > 0)
        tr.value = recent_vals[$urandom_range(recent_vals.size() - 1)];
      else if (k < 90)
        tr.value = value_pool[$urandom_range(POOL_N-1)];
    end else if (pick >= 95) begin
      tr.opcode = OP_UNUSED;
    end
    return tr;
  endfunction

  task automatic send_item(in_t tr);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tr.opcode == OP_INSERT) begin
      recent_vals.push_back(tr.value);
      if (recent_vals.size() > RECENT_N) void'(recent_vals.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int idle, int stall, bit long_hold);
    int i;
    in_idle_pct   = idle;
    out_stall_pct = stall;
    for (i = 0; i < POOL_N; i++) begin
      if (i < POOL_N / 2) value_pool[i] = $urandom;
      else value_pool[i] = 32'($urandom_range(8)) - 32'sd4;
    end
    if (long_hold) hold_token++;
    repeat (n) send_item(random_item());
    drain();
  endtask

  initial begin
    in_t plan [$];
    plan.push_back(mk(OP_READ, '0, 4'd0));
    plan.push_back(mk(OP_DELETE, 32'sd5, 4'd0));
    plan.push_back(mk(OP_UNUSED, 32'h1234, 4'd9));
    // fill to capacity: extremes, adjacent equal values
    plan.push_back(mk(OP_INSERT, 32'h7FFFFFFF, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'h80000000, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd0, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd0, 4'd0));
    plan.push_back(mk(OP_INSERT, -32'sd1, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd1, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd0, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd7, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd7, 4'd0));
    plan.push_back(mk(OP_INSERT, -32'sd5, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd100, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'h55555555, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'hAAAAAAAA, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd3, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd3, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd2, 4'd0));
    plan.push_back(mk(OP_INSERT, 32'sd9, 4'd0));
    plan.push_back(mk(OP_READ, '0, 4'd15));
    plan.push_back(mk(OP_READ, '1, 4'd0));
    plan.push_back(mk(OP_DELETE, 32'sd0, 4'd0));
    plan.push_back(mk(OP_DELETE, 32'h7FFFFFFF, 4'd0));
    plan.push_back(mk(OP_DELETE, 32'h80000000, 4'd0));
    plan.push_back(mk(OP_READ, '0, 4'd15));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_item(plan[i]);
    drain();

    run_phase(80, 0, 0, 1'b0);
    run_phase(80, 60, 0, 1'b0);
    run_phase(80, 0, 60, 1'b0);
    run_phase(80, 15, 15, 1'b0);
    // receiver holds off while the sender keeps offering
    run_phase(80, 0, 15, 1'b1);

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
